FILE: rtl/cbdr_pkg.sv
`default_nettype none
package cbdr_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned GlyphW = 21;
	localparam int unsigned ColorW = 24;
	localparam int unsigned AttrW = 8;
	localparam int unsigned ApbDataW = 32;
	localparam int unsigned ApbAddrW = 4;

	// Result queue; one finish item can push two rectangles at once.
	localparam int unsigned OfifoDepth = 4;
	localparam int unsigned OfifoPtrW = $clog2(OfifoDepth);
	localparam int unsigned OfifoCntW = $clog2(OfifoDepth + 1);

	typedef logic [CoordW-1:0] coord_t;

	// Register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_OLD_WIDTH = 2'd0,
		REG_OLD_HEIGHT = 2'd1,
		REG_NEW_WIDTH = 2'd2,
		REG_NEW_HEIGHT = 2'd3
	} reg_idx_t;

	typedef enum logic {
		FUNC_COMPARE = 1'b0,
		FUNC_FINISH = 1'b1
	} func_t;

	typedef struct packed {
		coord_t old_width;
		coord_t old_height;
		coord_t new_width;
		coord_t new_height;
	} cfg_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t w;
		coord_t h;
		logic   last;
	} rect_t;

	typedef struct packed {
		logic  push0;
		logic  push1;
		rect_t rect0;
		rect_t rect1;
	} push_t;

endpackage
`default_nettype wire

FILE: rtl/cbdr_cfg.sv
`default_nettype none
module cbdr_cfg
	import cbdr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ApbAddrW-1:0] paddr,
	input  wire logic [ApbDataW-1:0] pwdata,
	output logic      [ApbDataW-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	cfg_t    cfg_q;
	logic    wr_en;
	reg_idx_t idx;
	coord_t  rd_val;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[3:2]);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_OLD_WIDTH: cfg_q.old_width <= pwdata[CoordW-1:0];
				REG_OLD_HEIGHT: cfg_q.old_height <= pwdata[CoordW-1:0];
				REG_NEW_WIDTH: cfg_q.new_width <= pwdata[CoordW-1:0];
				REG_NEW_HEIGHT: cfg_q.new_height <= pwdata[CoordW-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_OLD_WIDTH: rd_val = cfg_q.old_width;
			REG_OLD_HEIGHT: rd_val = cfg_q.old_height;
			REG_NEW_WIDTH: rd_val = cfg_q.new_width;
			REG_NEW_HEIGHT: rd_val = cfg_q.new_height;
			default: rd_val = '0;
		endcase
		prdata = {{(ApbDataW - CoordW){1'b0}}, rd_val};
	end

endmodule
`default_nettype wire

FILE: rtl/cbdr_run.sv
`default_nettype none
module cbdr_run
	import cbdr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic en,
	input  wire logic func_s1,
	input  wire logic diff_s1,
	output push_t     push
);

	coord_t col_q, row_q, begin_q;
	logic   open_q;

	coord_t col_d, row_d, begin_d;
	logic   open_d;

	coord_t w, h, begin_eff;
	logic   rows_added, cols_added, last_col;
	rect_t  rect_rows, rect_cols, rect_run;

	always_comb begin
		w = (cfg.old_width < cfg.new_width) ? cfg.old_width : cfg.new_width;
		h = (cfg.old_height < cfg.new_height) ? cfg.old_height : cfg.new_height;
		rows_added = cfg.new_height > cfg.old_height;
		cols_added = cfg.new_width > cfg.old_width;
		last_col = col_q == (w - coord_t'(1));
		begin_eff = open_q ? begin_q : col_q;

		rect_rows.x = '0;
		rect_rows.y = h;
		rect_rows.w = cfg.new_width;
		rect_rows.h = cfg.new_height - cfg.old_height;
		rect_rows.last = !cols_added;

		rect_cols.x = w;
		rect_cols.y = '0;
		rect_cols.w = cfg.new_width - cfg.old_width;
		rect_cols.h = h;
		rect_cols.last = 1'b1;

		// A matching cell closes the run before the current column; a run that
		// reaches the last column closes including it.
		rect_run.x = begin_eff;
		rect_run.y = row_q;
		rect_run.w = (!diff_s1 && open_q) ? (col_q - begin_q) : (w - begin_eff);
		rect_run.h = coord_t'(1);
		rect_run.last = 1'b1;

		col_d = col_q;
		row_d = row_q;
		begin_d = begin_q;
		open_d = open_q;
		push.push0 = 1'b0;
		push.push1 = 1'b0;
		push.rect0 = rect_run;
		push.rect1 = rect_cols;

		if (func_t'(func_s1) == FUNC_FINISH) begin
			push.push0 = rows_added || cols_added;
			push.push1 = rows_added && cols_added;
			push.rect0 = rows_added ? rect_rows : rect_cols;
			col_d = '0;
			row_d = '0;
			begin_d = '0;
			open_d = 1'b0;
		end else if (w == '0 || row_q >= h) begin
			// Cell past the overlap: nothing changes.
		end else if (col_q >= w) begin
			col_d = '0;
			row_d = row_q + coord_t'(1);
			begin_d = '0;
			open_d = 1'b0;
		end else begin
			push.push0 = (!diff_s1 && open_q) || (diff_s1 && last_col);
			if (last_col) begin
				col_d = '0;
				row_d = row_q + coord_t'(1);
				begin_d = '0;
				open_d = 1'b0;
			end else begin
				col_d = col_q + coord_t'(1);
				open_d = diff_s1;
				begin_d = diff_s1 ? begin_eff : '0;
			end
		end

		if (!en) begin
			push.push0 = 1'b0;
			push.push1 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			begin_q <= '0;
			open_q <= 1'b0;
		end else if (en) begin
			col_q <= col_d;
			row_q <= row_d;
			begin_q <= begin_d;
			open_q <= open_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/cbdr_ofifo.sv
`default_nettype none
module cbdr_ofifo
	import cbdr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output logic       room,
	output logic       valid,
	output rect_t      head
);

	rect_t                mem_q [OfifoDepth];
	logic [OfifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OfifoCntW-1:0] cnt_q;
	logic                 do_pop;
	logic [OfifoPtrW-1:0] wr_ptr_p1;

	assign valid = cnt_q != '0;
	assign do_pop = pop && valid;
	assign head = mem_q[rd_ptr_q];
	// Room for two pushes regardless of what the receiver does this cycle.
	assign room = cnt_q <= OfifoCntW'(OfifoDepth - 2);
	assign wr_ptr_p1 = wr_ptr_q + OfifoPtrW'(1);

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= push.rect0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_p1] <= push.rect1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OfifoPtrW'(push.push0) + OfifoPtrW'(push.push1);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + OfifoPtrW'(1);
			end
			cnt_q <= cnt_q + OfifoCntW'(push.push0) + OfifoCntW'(push.push1)
				- OfifoCntW'(do_pop);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/cell_buffer_dirty_run_finder_core.sv
// Dirty-run finder for a character-cell frame buffer.
// The APB port sets old and new width and height (byte addresses 0, 4, 8, 12).
// The input channel takes one cell pair per transfer in raster order over the
// overlap of the two buffers, or a finish item that ends the frame. The output
// channel carries dirty rectangles; last marks the final one of an item.
// A compare item yields at most one rectangle, a finish item up to two.
// Each item is held in the input register; its rectangles then pass through the
// run tracking stage into the output queue. Throughput: one item per cycle while
// the output queue has room for two entries, and the queue drains one rectangle
// per cycle while the receiver does not stall.
// Reset clears the size registers, the column and row counters, the open run
// and the output queue; the block accepts items right after reset.
// When the receiver stalls, results collect in a four-entry queue and the
// input side stalls once fewer than two entries are free; nothing is lost.
`default_nettype none
module cell_buffer_dirty_run_finder_core
	import cbdr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ApbAddrW-1:0] paddr,
	input  wire logic [ApbDataW-1:0] pwdata,
	output logic      [ApbDataW-1:0] prdata,
	output logic                     pready,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                func,
	input  wire logic [GlyphW-1:0]   old_glyph,
	input  wire logic [GlyphW-1:0]   new_glyph,
	input  wire logic [ColorW-1:0]   old_fg,
	input  wire logic [ColorW-1:0]   new_fg,
	input  wire logic [ColorW-1:0]   old_bg,
	input  wire logic [ColorW-1:0]   new_bg,
	input  wire logic [AttrW-1:0]    old_attr,
	input  wire logic [AttrW-1:0]    new_attr,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [CoordW-1:0]   rect_x,
	output logic      [CoordW-1:0]   rect_y,
	output logic      [CoordW-1:0]   rect_w,
	output logic      [CoordW-1:0]   rect_h,
	output logic                     last
);

	cfg_t  cfg;
	push_t push;
	rect_t head;
	logic  valid_s1, func_s1, diff_s1;
	logic  room, adv, accept, diff;

	cbdr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Of the cell pair, only whether the cells differ is kept in the input register.
	assign diff = (old_glyph != new_glyph) || (old_fg != new_fg)
		|| (old_bg != new_bg) || (old_attr != new_attr);

	assign adv = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			diff_s1 <= diff;
		end
	end

	cbdr_run u_run (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.en     (adv),
		.func_s1(func_s1),
		.diff_s1(diff_s1),
		.push   (push)
	);

	cbdr_ofifo u_ofifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (!out_stall),
		.room  (room),
		.valid (out_valid),
		.head  (head)
	);

	assign rect_x = head.x;
	assign rect_y = head.y;
	assign rect_w = head.w;
	assign rect_h = head.h;
	assign last = head.last;

endmodule
`default_nettype wire

FILE: tb/dirty_rect_checker.sv
`timescale 1ns / 1ps
module dirty_rect_checker
	import cbdr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic                pready,
	input  wire logic [ApbAddrW-1:0] paddr,
	input  wire logic [ApbDataW-1:0] pwdata,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic                func,
	input  wire logic [GlyphW-1:0]   old_glyph,
	input  wire logic [GlyphW-1:0]   new_glyph,
	input  wire logic [ColorW-1:0]   old_fg,
	input  wire logic [ColorW-1:0]   new_fg,
	input  wire logic [ColorW-1:0]   old_bg,
	input  wire logic [ColorW-1:0]   new_bg,
	input  wire logic [AttrW-1:0]    old_attr,
	input  wire logic [AttrW-1:0]    new_attr,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire logic [CoordW-1:0]   rect_x,
	input  wire logic [CoordW-1:0]   rect_y,
	input  wire logic [CoordW-1:0]   rect_w,
	input  wire logic [CoordW-1:0]   rect_h,
	input  wire logic                last,
	output int                       errors,
	output int                       outstanding
);

	cfg_t   sizes;
	coord_t col_at;
	coord_t row_at;
	coord_t run_from;
	logic   run_open;
	logic   cell_differs;
	rect_t  want;
	rect_t  rects_due[$];

	initial begin
		errors = 0;
		outstanding = 0;
	end

	task automatic log_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		errors++;
	endtask

	function automatic void due_rect(input coord_t x, input coord_t y, input coord_t w,
		input coord_t h, input logic fin);
		rect_t r;
		r.x = x;
		r.y = y;
		r.w = w;
		r.h = h;
		r.last = fin;
		rects_due.insert(rects_due.size(), r);
	endfunction

	function automatic void end_row();
		col_at = '0;
		row_at = row_at + 1'b1;
		run_open = 1'b0;
		run_from = '0;
	endfunction

	// Advances the frame scan by one accepted item and queues the rectangles it yields.
	function automatic void advance_scan(input func_t op, input logic differs);
		coord_t span_w;
		coord_t span_h;
		logic   cols_grow;
		span_w = (sizes.old_width < sizes.new_width) ? sizes.old_width : sizes.new_width;
		span_h = (sizes.old_height < sizes.new_height) ? sizes.old_height : sizes.new_height;
		cols_grow = sizes.new_width > sizes.old_width;
		if (op == FUNC_FINISH) begin
			if (sizes.new_height > sizes.old_height)
				due_rect('0, span_h, sizes.new_width, sizes.new_height - sizes.old_height,
					!cols_grow);
			if (cols_grow)
				due_rect(span_w, '0, sizes.new_width - sizes.old_width, span_h, 1'b1);
			col_at = '0;
			row_at = '0;
			run_open = 1'b0;
			run_from = '0;
		end else if (span_w != 0 && row_at < span_h) begin
			if (col_at >= span_w) begin
				// The width shrank under an unfinished row: drop the cell and the run.
				end_row();
			end else begin
				if (differs && !run_open) begin
					run_open = 1'b1;
					run_from = col_at;
				end else if (!differs && run_open) begin
					due_rect(run_from, row_at, col_at - run_from, 16'd1, 1'b1);
					run_open = 1'b0;
					run_from = '0;
				end
				if (col_at == span_w - 1'b1) begin
					if (run_open)
						due_rect(run_from, row_at, span_w - run_from, 16'd1, 1'b1);
					end_row();
				end else begin
					col_at = col_at + 1'b1;
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sizes = '0;
			col_at = '0;
			row_at = '0;
			run_from = '0;
			run_open = 1'b0;
			rects_due.delete();
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_OLD_WIDTH: sizes.old_width = pwdata[CoordW-1:0];
					REG_OLD_HEIGHT: sizes.old_height = pwdata[CoordW-1:0];
					REG_NEW_WIDTH: sizes.new_width = pwdata[CoordW-1:0];
					REG_NEW_HEIGHT: sizes.new_height = pwdata[CoordW-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (rects_due.size() == 0) begin
					log_error($sformatf("rectangle (%0d,%0d,%0d,%0d) with none expected",
						rect_x, rect_y, rect_w, rect_h));
				end else begin
					want = rects_due.pop_front();
					if (rect_x !== want.x)
						log_error($sformatf("rect_x %0d, expected %0d", rect_x, want.x));
					if (rect_y !== want.y)
						log_error($sformatf("rect_y %0d, expected %0d", rect_y, want.y));
					if (rect_w !== want.w)
						log_error($sformatf("rect_w %0d, expected %0d", rect_w, want.w));
					if (rect_h !== want.h)
						log_error($sformatf("rect_h %0d, expected %0d", rect_h, want.h));
					if (last !== want.last)
						log_error($sformatf("last %0b, expected %0b", last, want.last));
				end
			end
			if (in_valid && !in_stall) begin
				cell_differs = (old_glyph != new_glyph) || (old_fg != new_fg) ||
					(old_bg != new_bg) || (old_attr != new_attr);
				advance_scan(func_t'(func), cell_differs);
			end
			outstanding = rects_due.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import cbdr_pkg::*;

	localparam int GlyphMax = 1114111;
	localparam int ItemTarget = 1400;
	localparam int SettleCycles = 4;
	localparam int HoldCycles = 150;
	localparam int QuietLimit = 2000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ApbAddrW-1:0] paddr = '0;
	logic [ApbDataW-1:0] pwdata = '0;
	logic [ApbDataW-1:0] prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                func = 1'b0;
	logic [GlyphW-1:0]   old_glyph = '0;
	logic [GlyphW-1:0]   new_glyph = '0;
	logic [ColorW-1:0]   old_fg = '0;
	logic [ColorW-1:0]   new_fg = '0;
	logic [ColorW-1:0]   old_bg = '0;
	logic [ColorW-1:0]   new_bg = '0;
	logic [AttrW-1:0]    old_attr = '0;
	logic [AttrW-1:0]    new_attr = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [CoordW-1:0]   rect_x;
	logic [CoordW-1:0]   rect_y;
	logic [CoordW-1:0]   rect_w;
	logic [CoordW-1:0]   rect_h;
	logic                last;

	int rect_errors;
	int rects_outstanding;
	int useful_items = 0;
	int quiet_cycles = 0;
	bit gaps_on = 1'b1;
	bit hold_now = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	cell_buffer_dirty_run_finder_core DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.old_glyph(old_glyph), .new_glyph(new_glyph), .old_fg(old_fg), .new_fg(new_fg),
		.old_bg(old_bg), .new_bg(new_bg), .old_attr(old_attr), .new_attr(new_attr),
		.out_valid(out_valid), .out_stall(out_stall),
		.rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h), .last(last)
	);

	dirty_rect_checker rect_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.old_glyph(old_glyph), .new_glyph(new_glyph), .old_fg(old_fg), .new_fg(new_fg),
		.old_bg(old_bg), .new_bg(new_bg), .old_attr(old_attr), .new_attr(new_attr),
		.out_valid(out_valid), .out_stall(out_stall),
		.rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h), .last(last),
		.errors(rect_errors), .outstanding(rects_outstanding)
	);

	// Receiver: random stalls, or one long hold-off on request so the block backs up.
	initial begin : receiver
		int held;
		forever begin
			@(posedge clk);
			if (hold_now) begin
				out_stall <= 1'b1;
				for (held = 0; held < HoldCycles; held++)
					@(posedge clk);
				hold_now = 1'b0;
			end
			out_stall <= gaps_on && ($urandom_range(99) < 36);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input coord_t value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ApbAddrW'({idx, 2'b00});
		pwdata <= ApbDataW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_sizes(input coord_t ow, input coord_t oh, input coord_t nw,
		input coord_t nh);
		write_reg(REG_OLD_WIDTH, ow);
		write_reg(REG_OLD_HEIGHT, oh);
		write_reg(REG_NEW_WIDTH, nw);
		write_reg(REG_NEW_HEIGHT, nh);
	endtask

	// Valid stays high from one transfer to the next unless a gap is drawn.
	task automatic send_item(input func_t op,
		input logic [GlyphW-1:0] og, input logic [GlyphW-1:0] ng,
		input logic [ColorW-1:0] ofg, input logic [ColorW-1:0] nfg,
		input logic [ColorW-1:0] obg, input logic [ColorW-1:0] nbg,
		input logic [AttrW-1:0] oat, input logic [AttrW-1:0] nat);
		while (gaps_on && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		old_glyph <= og;
		new_glyph <= ng;
		old_fg <= ofg;
		new_fg <= nfg;
		old_bg <= obg;
		new_bg <= nbg;
		old_attr <= oat;
		new_attr <= nat;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_cell(input bit differ);
		logic [GlyphW-1:0] og, ng;
		logic [ColorW-1:0] ofg, nfg, obg, nbg;
		logic [AttrW-1:0]  oat, nat;
		og = GlyphW'($urandom_range(GlyphMax));
		ofg = ColorW'($urandom);
		obg = ColorW'($urandom);
		oat = AttrW'($urandom);
		ng = og;
		nfg = ofg;
		nbg = obg;
		nat = oat;
		// Mostly a single flipped bit, so every comparator bit but the glyph's top bit gets exercised.
		if (differ) begin
			case ($urandom_range(3))
				0: begin
					ng = og ^ (GlyphW'(1) << $urandom_range(19));
					if (ng > GlyphMax)
						ng = og ^ GlyphW'(1);
				end
				1: nfg = ofg ^ (ColorW'(1) << $urandom_range(23));
				2: nbg = obg ^ (ColorW'(1) << $urandom_range(23));
				default: nat = oat ^ (AttrW'(1) << $urandom_range(7));
			endcase
			if ($urandom_range(3) == 0)
				nbg = ~obg;
		end
		send_item(FUNC_COMPARE, og, ng, ofg, nfg, obg, nbg, oat, nat);
	endtask

	task automatic send_finish();
		send_item(FUNC_FINISH, GlyphW'($urandom_range(GlyphMax)),
			GlyphW'($urandom_range(GlyphMax)), ColorW'($urandom), ColorW'($urandom),
			ColorW'($urandom), ColorW'($urandom), AttrW'($urandom), AttrW'($urandom));
	endtask

	// Items that yield nothing may still be in the pipeline, hence the extra cycles.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (rects_outstanding != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	function automatic coord_t pick_dim();
		case ($urandom_range(19))
			0: return '0;
			1: return '1;
			2: return coord_t'($urandom);
			default: return coord_t'($urandom_range(8, 1));
		endcase
	endfunction

	task automatic run_frame(input coord_t ow, input coord_t oh, input coord_t nw,
		input coord_t nh, input int diff_pct, input bit hold);
		coord_t span_w, span_h;
		longint area;
		int overlap, cells;
		set_sizes(ow, oh, nw, nh);
		span_w = (ow < nw) ? ow : nw;
		span_h = (oh < nh) ? oh : nh;
		area = longint'(span_w) * longint'(span_h);
		overlap = (area > 64) ? 64 : int'(area);
		cells = overlap;
		// Now and then a frame is cut short or runs past the overlap.
		case ($urandom_range(7))
			0: cells = $urandom_range(overlap);
			1: cells = overlap + $urandom_range(3, 1);
			default: ;
		endcase
		hold_now = hold;
		for (int i = 0; i < cells; i++) begin
			send_cell($urandom_range(99) < diff_pct);
			if (i < overlap)
				useful_items++;
		end
		send_finish();
		useful_items++;
		wait_idle();
	endtask

	initial begin : stimulus
		int frame_no;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Field extremes; runs closed by a matching cell and by the end of a row,
		// then a cell past the overlap.
		set_sizes(16'd3, 16'd2, 16'd3, 16'd2);
		send_item(FUNC_COMPARE, GlyphW'(GlyphMax), '0, '0, '0, '0, '0, '0, '0);
		send_item(FUNC_COMPARE, GlyphW'(GlyphMax), GlyphW'(GlyphMax), '1, '1, '1, '1,
			'1, '1);
		send_item(FUNC_COMPARE, '0, '0, '1, '0, '0, '0, '0, '0);
		send_item(FUNC_COMPARE, '0, '0, '0, '0, '1, '0, '0, '0);
		send_item(FUNC_COMPARE, '0, '0, '0, '0, '0, '0, '1, '0);
		send_item(FUNC_COMPARE, '0, GlyphW'(GlyphMax), '0, '1, '0, '1, '0, '1);
		send_cell(1'b1);
		send_finish();
		wait_idle();

		// The width shrinks under an open run: the run is dropped and the row advances.
		set_sizes(16'd4, 16'd2, 16'd4, 16'd2);
		send_cell(1'b1);
		send_cell(1'b1);
		wait_idle();
		write_reg(REG_NEW_WIDTH, 16'd1);
		send_cell(1'b1);
		send_cell(1'b1);
		send_cell(1'b0);
		send_finish();
		wait_idle();

		// Rows and columns added, with a run left open at the finish.
		set_sizes(16'd2, 16'd1, 16'hFFFF, 16'hFFFF);
		send_cell(1'b1);
		send_finish();
		wait_idle();

		// Zero overlap width, then rows added alone.
		set_sizes(16'd0, 16'hFFFF, 16'd5, 16'd0);
		send_cell(1'b1);
		send_finish();
		wait_idle();
		set_sizes(16'd3, 16'd1, 16'd2, 16'd3);
		send_finish();
		wait_idle();

		set_sizes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_cell(1'b1);
		send_cell(1'b0);
		send_finish();
		wait_idle();

		frame_no = 0;
		while (useful_items < ItemTarget) begin
			gaps_on = (frame_no < 30 || frame_no > 45);
			if (frame_no == 12 || frame_no == 70)
				run_frame(16'd8, 16'd8, 16'd8, 16'd8, 50, 1'b1);
			else
				run_frame(pick_dim(), pick_dim(), pick_dim(), pick_dim(),
					$urandom_range(90, 10), 1'b0);
			frame_no++;
		end
		gaps_on = 1'b1;
		wait_idle();

		if (rect_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
